>>> hdl/hhtok_pkg.sv
`default_nettype none
package hhtok_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [2:0]  kind_type;
   typedef logic [2:0]  method_type;
   typedef logic [9:0]  code_type;
   typedef logic [15:0] len_type;

   // Result kinds.
   localparam kind_type KIND_SKIP    = 3'd0;
   localparam kind_type KIND_URL     = 3'd1;
   localparam kind_type KIND_KEY     = 3'd2;
   localparam kind_type KIND_VALUE   = 3'd3;
   localparam kind_type KIND_COMMIT  = 3'd4;
   localparam kind_type KIND_DISCARD = 3'd5;
   localparam kind_type KIND_DONE    = 3'd6;
   localparam kind_type KIND_ERROR   = 3'd7;

   // Method codes.
   localparam method_type METHOD_NONE = 3'd0;
   localparam method_type METHOD_GET  = 3'd1;
   localparam method_type METHOD_POST = 3'd2;
   localparam method_type METHOD_HEAD = 3'd3;
   localparam method_type METHOD_RESP = 3'd4;

   localparam byte_type CH_CR    = 8'h0D;
   localparam byte_type CH_LF    = 8'h0A;
   localparam byte_type CH_SPACE = 8'h20;
   localparam byte_type CH_COLON = 8'h3A;
   localparam byte_type CH_SEMI  = 8'h3B;
   localparam byte_type CH_ZERO  = 8'h30;
   localparam byte_type CH_NINE  = 8'h39;
   localparam byte_type CH_UPPER_A = 8'h41;
   localparam byte_type CH_UPPER_Z = 8'h5A;
   localparam byte_type CASE_BIT = 8'h20;

   localparam logic [31:0] CRLF_CRLF = 32'h0D0A0D0A;

   // Method prefixes, first character at index 0. GET has an unused fourth slot.
   localparam logic [3:0][7:0] PAT_POST = {8'h54, 8'h53, 8'h4F, 8'h50};
   localparam logic [3:0][7:0] PAT_GET  = {8'h00, 8'h54, 8'h45, 8'h47};
   localparam logic [3:0][7:0] PAT_HEAD = {8'h44, 8'h41, 8'h45, 8'h48};
   localparam logic [3:0][7:0] PAT_HTTP = {8'h50, 8'h54, 8'h54, 8'h48};

   localparam logic [3:0] URL_OFF_GET   = 4'd4;
   localparam logic [3:0] URL_OFF_OTHER = 4'd5;
   localparam logic [3:0] POS_MAX       = 4'd15;

   typedef enum logic [6:0] {
      PH_FIRST   = 7'b0000001,
      PH_KEY     = 7'b0000010,
      PH_SKIP1   = 7'b0000100,
      PH_VAL     = 7'b0001000,
      PH_VALSKIP = 7'b0010000,
      PH_DONE    = 7'b0100000,
      PH_FAIL    = 7'b1000000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  first_line_pos;
      logic [3:0]  prefix_alive;
      logic        cr_held;
      logic        line_empty;
      logic        colon_seen;
      logic        span_closed;
      logic [31:0] tail_bytes;
      method_type  method_reg;
      code_type    code_acc;
      logic [1:0]  code_digits;
      len_type     byte_count;
      logic        end_seen;
      logic        failed;
   } parse_state_type;

   typedef struct packed {
      kind_type   kind;
      byte_type   out_char;
      logic       run_last;
      method_type method_code;
      code_type   status_code;
      logic       finished;
      logic       accepted;
      len_type    total_length;
   } rsp_type;

   typedef struct packed {
      parse_state_type st;
      rsp_type         rsp;
   } step_type;

   localparam parse_state_type STATE_RESET = '{
      phase:          PH_FIRST,
      first_line_pos: 4'd0,
      prefix_alive:   4'hF,
      cr_held:        1'b0,
      line_empty:     1'b1,
      colon_seen:     1'b0,
      span_closed:    1'b0,
      tail_bytes:     32'd0,
      method_reg:     METHOD_NONE,
      code_acc:       10'd0,
      code_digits:    2'd0,
      byte_count:     16'd0,
      end_seen:       1'b0,
      failed:         1'b0
   };

endpackage
`default_nettype wire

>>> hdl/http_header_tokenizer.sv
// HTTP header tokenizer.
// Input channel (req_*): one header byte per beat, with req_end_of_buffer set on
// the final byte of a buffer. Result channel (rsp_*): tagged bytes, field commit
// or discard marks, and one verdict beat (header done or error) per buffer.
// A byte gives zero, one or two result beats; rsp_run_last marks the last one.
// A CR is held back until the next byte shows whether it ends a line.
// A result is written into the result queue when its byte is accepted and
// is offered once the results ahead of it are taken. One byte per cycle while
// each byte gives at most one result and the receiver takes results; a byte
// giving two results drains one beat at a time. The parse state is registered
// at acceptance, and results wait in a four-entry result queue. req_ready is
// high while that queue holds two results or fewer, so it depends only on
// registers. When the receiver stalls, the queue fills and req_ready drops;
// nothing is lost. Reset clears the parse state and empties the queue. After
// a verdict, the next byte starts a new buffer from the reset state.
`default_nettype none
module http_header_tokenizer (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire  hhtok_pkg::byte_type req_in_char,
   input  wire                       req_end_of_buffer,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output hhtok_pkg::kind_type       rsp_kind,
   output hhtok_pkg::byte_type       rsp_out_char,
   output logic                      rsp_run_last,
   output hhtok_pkg::method_type     rsp_method_code,
   output hhtok_pkg::code_type       rsp_status_code,
   output logic                      rsp_finished,
   output logic                      rsp_accepted,
   output hhtok_pkg::len_type        rsp_total_length
);
   import hhtok_pkg::*;

   function automatic rsp_type make_rsp(parse_state_type s, kind_type kind, byte_type ch,
                                        logic fin, logic acc);
      rsp_type r;
      r.kind         = kind;
      r.out_char     = ch;
      r.run_last     = 1'b0;
      r.method_code  = s.method_reg;
      r.status_code  = s.code_acc;
      r.finished     = fin;
      r.accepted     = acc;
      r.total_length = s.byte_count;
      return r;
   endfunction

   function automatic byte_type to_lower(byte_type c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_BIT) : c;
   endfunction

   function automatic step_type first_content(parse_state_type s_in, byte_type c);
      parse_state_type s;
      kind_type        kind;
      logic [1:0]      idx;
      logic [3:0]      off;
      logic [13:0]     acc_ext;
      step_type        res;
      s    = s_in;
      kind = KIND_SKIP;
      idx  = s.first_line_pos[1:0];
      s.line_empty = 1'b0;
      if (s.method_reg == METHOD_NONE) begin
         if (s.first_line_pos < 4'd4) begin
            if (c != PAT_POST[idx]) s.prefix_alive[0] = 1'b0;
            if (s.first_line_pos >= 4'd3 || c != PAT_GET[idx]) s.prefix_alive[1] = 1'b0;
            if (c != PAT_HEAD[idx]) s.prefix_alive[2] = 1'b0;
            if (c != PAT_HTTP[idx]) s.prefix_alive[3] = 1'b0;
         end else begin
            s.prefix_alive = 4'd0;
         end
         if (s.first_line_pos == 4'd2 && s.prefix_alive[1]) begin
            s.method_reg = METHOD_GET;
         end else if (s.first_line_pos == 4'd3 && s.prefix_alive[0]) begin
            s.method_reg = METHOD_POST;
         end else if (s.first_line_pos == 4'd3 && s.prefix_alive[2]) begin
            s.method_reg = METHOD_HEAD;
         end else if (s.first_line_pos == 4'd3 && s.prefix_alive[3]) begin
            s.method_reg = METHOD_RESP;
         end
         if (s.method_reg == METHOD_NONE && s.prefix_alive == 4'd0) begin
            s.failed = 1'b1;
            s.phase  = PH_FAIL;
         end
      end else if (s.method_reg != METHOD_RESP) begin
         off = (s.method_reg == METHOD_GET) ? URL_OFF_GET : URL_OFF_OTHER;
         if (s.first_line_pos >= off && !s.span_closed) begin
            if (c == CH_SPACE) s.span_closed = 1'b1;
            else kind = KIND_URL;
         end
      end else if (!s.span_closed) begin
         if (c == CH_SPACE) s.span_closed = 1'b1;
      end else if (s.code_digits != 2'd3) begin
         if (c >= CH_ZERO && c <= CH_NINE) begin
            // code * 10 as two shifted copies, plus the digit.
            acc_ext = {1'b0, s.code_acc, 3'b000} + {3'b000, s.code_acc, 1'b0}
                      + {6'd0, c - CH_ZERO};
            s.code_acc    = acc_ext[9:0];
            s.code_digits = s.code_digits + 2'd1;
         end else begin
            s.code_digits = 2'd3;
         end
      end
      if (s.first_line_pos != POS_MAX) s.first_line_pos = s.first_line_pos + 4'd1;
      res.st  = s;
      res.rsp = make_rsp(s, kind, c, 1'b0, 1'b0);
      return res;
   endfunction

   function automatic step_type content(parse_state_type s_in, byte_type c);
      parse_state_type s;
      kind_type        kind;
      byte_type        ch;
      step_type        res;
      s    = s_in;
      kind = KIND_SKIP;
      ch   = c;
      res  = '0;
      unique case (s.phase)
         PH_FIRST: begin
            res = first_content(s, c);
         end
         PH_KEY: begin
            s.line_empty = 1'b0;
            if (c == CH_COLON) begin
               s.colon_seen = 1'b1;
               s.phase      = PH_SKIP1;
            end else begin
               kind = KIND_KEY;
               ch   = to_lower(c);
            end
         end
         PH_SKIP1: begin
            s.line_empty = 1'b0;
            s.phase      = PH_VAL;
         end
         PH_VAL: begin
            s.line_empty = 1'b0;
            if (c == CH_SEMI) begin
               s.phase = PH_VALSKIP;
            end else begin
               kind = KIND_VALUE;
               ch   = to_lower(c);
            end
         end
         PH_VALSKIP: begin
            s.line_empty = 1'b0;
         end
         default: begin
         end
      endcase
      if (s.phase != PH_FIRST || s_in.phase != PH_FIRST) begin
         res.st  = s;
         res.rsp = make_rsp(s, kind, ch, 1'b0, 1'b0);
      end
      return res;
   endfunction

   function automatic step_type line_end(parse_state_type s_in);
      parse_state_type s;
      kind_type        kind;
      byte_type        ch;
      step_type        res;
      s    = s_in;
      kind = KIND_SKIP;
      ch   = CH_LF;
      if (s.phase == PH_FIRST) begin
         if (s.line_empty || s.method_reg == METHOD_NONE) begin
            s.failed = 1'b1;
            s.phase  = PH_FAIL;
         end else begin
            s.phase = PH_KEY;
         end
      end else if (s.line_empty) begin
         s.phase = PH_DONE;
      end else begin
         kind  = s.colon_seen ? KIND_COMMIT : KIND_DISCARD;
         ch    = '0;
         s.phase = PH_KEY;
      end
      s.line_empty = 1'b1;
      s.colon_seen = 1'b0;
      res.st  = s;
      res.rsp = make_rsp(s, kind, ch, 1'b0, 1'b0);
      return res;
   endfunction

   parse_state_type st_ff, st_in;
   rsp_type         queue_ff [4];
   logic [1:0]      wr_ptr_ff, wr_ptr_in;
   logic [1:0]      rd_ptr_ff, rd_ptr_in;
   logic [2:0]      count_ff, count_in;

   logic            accept;
   logic            pop;
   logic [1:0]      n_res;
   rsp_type         res0;
   rsp_type         res1;

   assign req_ready = (count_ff <= 3'd2);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count_ff != 3'd0);
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      parse_state_type s;
      step_type        stp;
      logic            ok;
      logic            handled;
      s       = st_ff.end_seen ? STATE_RESET : st_ff;
      res0    = '0;
      res1    = '0;
      n_res   = 2'd0;
      ok      = 1'b0;
      handled = 1'b0;
      stp     = '0;
      if (s.byte_count != 16'hFFFF) s.byte_count = s.byte_count + 16'd1;
      s.tail_bytes = {s.tail_bytes[23:0], req_in_char};

      if (req_end_of_buffer) begin
         ok         = !s.failed && (s.tail_bytes == CRLF_CRLF);
         s.end_seen = 1'b1;
         s.cr_held  = 1'b0;
         res0       = make_rsp(s, ok ? KIND_DONE : KIND_ERROR, '0, 1'b1, ok);
         n_res      = 2'd1;
      end else if (s.phase == PH_DONE || s.phase == PH_FAIL) begin
         res0  = make_rsp(s, KIND_SKIP, req_in_char, 1'b0, 1'b0);
         n_res = 2'd1;
      end else begin
         if (s.cr_held) begin
            s.cr_held = 1'b0;
            if (req_in_char == CH_LF) begin
               stp     = line_end(s);
               s       = stp.st;
               res0    = stp.rsp;
               n_res   = 2'd1;
               handled = 1'b1;
            end else begin
               // A lone CR counts as an ordinary content byte.
               stp   = content(s, CH_CR);
               s     = stp.st;
               res0  = stp.rsp;
               n_res = 2'd1;
            end
         end
         if (!handled) begin
            if (s.phase == PH_DONE || s.phase == PH_FAIL) begin
               stp.rsp = make_rsp(s, KIND_SKIP, req_in_char, 1'b0, 1'b0);
            end else if (req_in_char == CH_CR) begin
               s.cr_held = 1'b1;
            end else begin
               stp = content(s, req_in_char);
               s   = stp.st;
            end
            if (!s.cr_held) begin
               if (n_res == 2'd0) res0 = stp.rsp;
               else res1 = stp.rsp;
               n_res = n_res + 2'd1;
            end
         end
      end

      if (n_res == 2'd1) res0.run_last = 1'b1;
      if (n_res == 2'd2) res1.run_last = 1'b1;
      st_in = s;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + n_res;
         count_in  = count_in + {1'b0, n_res};
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
         count_in  = count_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= STATE_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) st_ff <= st_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && n_res != 2'd0) queue_ff[wr_ptr_ff] <= res0;
      if (accept && n_res == 2'd2) queue_ff[wr_ptr_ff + 2'd1] <= res1;
   end

   rsp_type head;
   assign head             = queue_ff[rd_ptr_ff];
   assign rsp_kind         = head.kind;
   assign rsp_out_char     = head.out_char;
   assign rsp_run_last     = head.run_last;
   assign rsp_method_code  = head.method_code;
   assign rsp_status_code  = head.status_code;
   assign rsp_finished     = head.finished;
   assign rsp_accepted     = head.accepted;
   assign rsp_total_length = head.total_length;

   // The queue must never be pushed beyond its four entries.
   assert property (@(posedge clock) disable iff (reset) count_ff <= 3'd4)
      else $error("result queue overflow");

   // A verdict is always the last beat of its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_run_last)
      else $error("verdict beat without run_last");

   // An accepted header only comes with a header-done verdict.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_finished && rsp_kind == KIND_DONE)
      else $error("accepted flag on a non-verdict beat");

   // The byte that closes a buffer pushes exactly one result.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_buffer |=> count_ff == $past(count_ff) + 3'd1 - {2'd0, $past(pop)})
      else $error("end of buffer did not give one verdict");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import hhtok_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 2000000;
   localparam int unsigned RANDOM_BYTES = 540;
   localparam int unsigned LONG_FILL    = 200;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   byte_type req_in_char = 8'h00;
   logic     req_end_of_buffer = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   kind_type   rsp_kind;
   byte_type   rsp_out_char;
   logic       rsp_run_last;
   method_type rsp_method_code;
   code_type   rsp_status_code;
   logic       rsp_finished;
   logic       rsp_accepted;
   len_type    rsp_total_length;

   http_header_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_char      (req_in_char),
      .req_end_of_buffer(req_end_of_buffer),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_char     (rsp_out_char),
      .rsp_run_last     (rsp_run_last),
      .rsp_method_code  (rsp_method_code),
      .rsp_status_code  (rsp_status_code),
      .rsp_finished     (rsp_finished),
      .rsp_accepted     (rsp_accepted),
      .rsp_total_length (rsp_total_length)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Tokenizer state as predicted by the testbench, and the tags still owed.
   parse_state_type tok = STATE_RESET;
   rsp_type         pending_tags[$];
   byte_type        frame_q[$];

   int unsigned bytes_sent  = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left  = 0;
   int          error_count = 0;
   bit          idle_on     = 1'b1;

   // ---------------------------------------------------------------- predictor

   function automatic byte_type fold_case(input byte_type c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_BIT) : c;
   endfunction

   function automatic rsp_type make_tag(input kind_type k, input byte_type ch,
                                        input logic fin, input logic acc);
      rsp_type r;
      r.kind         = k;
      r.out_char     = ch;
      r.run_last     = 1'b0;
      r.method_code  = tok.method_reg;
      r.status_code  = tok.code_acc;
      r.finished     = fin;
      r.accepted     = acc;
      r.total_length = tok.byte_count;
      return r;
   endfunction

   function automatic kind_type scan_first_line(input byte_type c);
      logic [3:0] p;
      logic [3:0] url_off;
      kind_type   k;
      p = tok.first_line_pos;
      k = KIND_SKIP;
      tok.line_empty = 1'b0;
      if (tok.method_reg == METHOD_NONE) begin
         if (p < 4) begin
            if (c != PAT_POST[p[1:0]]) tok.prefix_alive[0] = 1'b0;
            if (p >= 3 || c != PAT_GET[p[1:0]]) tok.prefix_alive[1] = 1'b0;
            if (c != PAT_HEAD[p[1:0]]) tok.prefix_alive[2] = 1'b0;
            if (c != PAT_HTTP[p[1:0]]) tok.prefix_alive[3] = 1'b0;
         end else begin
            tok.prefix_alive = 4'h0;
         end
         if (p == 2 && tok.prefix_alive[1]) tok.method_reg = METHOD_GET;
         else if (p == 3 && tok.prefix_alive[0]) tok.method_reg = METHOD_POST;
         else if (p == 3 && tok.prefix_alive[2]) tok.method_reg = METHOD_HEAD;
         else if (p == 3 && tok.prefix_alive[3]) tok.method_reg = METHOD_RESP;
         if (tok.method_reg == METHOD_NONE && tok.prefix_alive == 4'h0) begin
            tok.failed = 1'b1;
            tok.phase  = PH_FAIL;
         end
      end else if (tok.method_reg != METHOD_RESP) begin
         url_off = (tok.method_reg == METHOD_GET) ? URL_OFF_GET : URL_OFF_OTHER;
         if (p >= url_off && !tok.span_closed) begin
            if (c == CH_SPACE) tok.span_closed = 1'b1;
            else k = KIND_URL;
         end
      end else if (!tok.span_closed) begin
         if (c == CH_SPACE) tok.span_closed = 1'b1;
      end else if (tok.code_digits < 3) begin
         if (c >= CH_ZERO && c <= CH_NINE) begin
            tok.code_acc    = code_type'(tok.code_acc * 10 + (c - CH_ZERO));
            tok.code_digits = tok.code_digits + 2'd1;
         end else begin
            tok.code_digits = 2'd3;
         end
      end
      if (tok.first_line_pos < POS_MAX) tok.first_line_pos = tok.first_line_pos + 4'd1;
      return k;
   endfunction

   function automatic rsp_type tag_content(input byte_type c);
      kind_type k;
      byte_type ch;
      k  = KIND_SKIP;
      ch = c;
      case (tok.phase)
         PH_FIRST: k = scan_first_line(c);
         PH_KEY: begin
            tok.line_empty = 1'b0;
            if (c == CH_COLON) begin
               tok.colon_seen = 1'b1;
               tok.phase      = PH_SKIP1;
            end else begin
               k  = KIND_KEY;
               ch = fold_case(c);
            end
         end
         PH_SKIP1: begin
            tok.line_empty = 1'b0;
            tok.phase      = PH_VAL;
         end
         PH_VAL: begin
            tok.line_empty = 1'b0;
            if (c == CH_SEMI) begin
               tok.phase = PH_VALSKIP;
            end else begin
               k  = KIND_VALUE;
               ch = fold_case(c);
            end
         end
         PH_VALSKIP: tok.line_empty = 1'b0;
         default: ;
      endcase
      return make_tag(k, ch, 1'b0, 1'b0);
   endfunction

   function automatic rsp_type tag_line_end();
      kind_type k;
      byte_type ch;
      k  = KIND_SKIP;
      ch = CH_LF;
      if (tok.phase == PH_FIRST) begin
         if (tok.line_empty || tok.method_reg == METHOD_NONE) begin
            tok.failed = 1'b1;
            tok.phase  = PH_FAIL;
         end else begin
            tok.phase = PH_KEY;
         end
      end else if (tok.line_empty) begin
         tok.phase = PH_DONE;
      end else begin
         k  = tok.colon_seen ? KIND_COMMIT : KIND_DISCARD;
         ch = 8'h00;
         tok.phase = PH_KEY;
      end
      tok.line_empty = 1'b1;
      tok.colon_seen = 1'b0;
      return make_tag(k, ch, 1'b0, 1'b0);
   endfunction

   // Works out the tags that one accepted header byte causes.
   task automatic predict_byte(input byte_type c, input logic last);
      rsp_type tags [2];
      rsp_type t;
      int      n;
      logic    ok;
      logic    line_ended;
      n = 0;
      line_ended = 1'b0;
      if (tok.end_seen) tok = STATE_RESET;
      if (tok.byte_count != 16'hFFFF) tok.byte_count = tok.byte_count + 16'd1;
      tok.tail_bytes = {tok.tail_bytes[23:0], c};
      if (last) begin
         // The final byte is counted but never parsed; a held CR is dropped.
         ok = !tok.failed && tok.tail_bytes == CRLF_CRLF;
         tok.end_seen = 1'b1;
         tok.cr_held  = 1'b0;
         tags[n] = make_tag(ok ? KIND_DONE : KIND_ERROR, 8'h00, 1'b1, ok);
         n++;
      end else if (tok.phase == PH_DONE || tok.phase == PH_FAIL) begin
         tags[n] = make_tag(KIND_SKIP, c, 1'b0, 1'b0);
         n++;
      end else begin
         if (tok.cr_held) begin
            tok.cr_held = 1'b0;
            if (c == CH_LF) begin
               tags[n] = tag_line_end();
               n++;
               line_ended = 1'b1;
            end else begin
               tags[n] = tag_content(CH_CR);
               n++;
            end
         end
         if (!line_ended) begin
            if (tok.phase == PH_DONE || tok.phase == PH_FAIL) begin
               tags[n] = make_tag(KIND_SKIP, c, 1'b0, 1'b0);
               n++;
            end else if (c == CH_CR) begin
               tok.cr_held = 1'b1;
            end else begin
               tags[n] = tag_content(c);
               n++;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         t = tags[i];
         t.run_last = (i == n - 1);
         pending_tags.push_back(t);
      end
   endtask

   // ---------------------------------------------------------------- driving

   task automatic send_byte(input byte_type c, input logic last);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_char       <= c;
      req_end_of_buffer <= last;
      do @(posedge clock); while (!req_ready);
      predict_byte(c, last);
      bytes_sent++;
   endtask

   task automatic put_byte(input byte_type c);
      frame_q.push_back(c);
   endtask

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
   endtask

   task automatic put_crlf();
      frame_q.push_back(CH_CR);
      frame_q.push_back(CH_LF);
   endtask

   // Sends the assembled buffer; its last byte carries the end-of-buffer flag.
   task automatic send_frame();
      if (frame_q.size() == 0) put_byte(CH_LF);
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      frame_q.delete();
   endtask

   // Holds the sender off until every tag owed has come back.
   task automatic wait_all_tags();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_tags.size() != 0);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_tag();
      rsp_type want;
      if (pending_tags.size() == 0) begin
         $display("%0t: result beat with nothing expected, got kind %0d char %0h",
                  $time, rsp_kind, rsp_out_char);
         error_count++;
      end else begin
         want = pending_tags.pop_front();
         check_field("kind", 16'(want.kind), 16'(rsp_kind));
         check_field("out_char", 16'(want.out_char), 16'(rsp_out_char));
         check_field("run_last", 16'(want.run_last), 16'(rsp_run_last));
         check_field("method_code", 16'(want.method_code), 16'(rsp_method_code));
         check_field("status_code", 16'(want.status_code), 16'(rsp_status_code));
         check_field("finished", 16'(want.finished), 16'(rsp_finished));
         check_field("accepted", 16'(want.accepted), 16'(rsp_accepted));
         check_field("total_length", want.total_length, rsp_total_length);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_tag();
         stall_left = idle_on ? $urandom_range(0, 14) : 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_request_lines();
      idle_on = 1'b1;
      put_str("GET /index.html HTTP/1.1");
      put_crlf();
      put_str("Host: Example.COM");
      put_crlf();
      put_str("Accept: Text/HTML;q=0.9");
      put_crlf();
      put_str("Empty:");
      put_crlf();
      put_str("X-No-Colon-Here");
      put_crlf();
      put_crlf();
      send_frame();
      put_str("POST /submit?id=7 HTTP/1.0");
      put_crlf();
      put_str("Content-Length: 12");
      put_crlf();
      put_crlf();
      send_frame();
      put_str("HEAD / HTTP/1.1");
      put_crlf();
      put_crlf();
      send_frame();
      // The line ends before the URL offset, so no URL bytes come out.
      put_str("GET");
      put_crlf();
      put_crlf();
      send_frame();
      wait_all_tags();
   endtask

   task automatic test_status_lines();
      put_str("HTTP/1.1 404 Not Found");
      put_crlf();
      put_str("Server: T");
      put_crlf();
      put_crlf();
      send_frame();
      put_str("HTTP/1.1 9990");
      put_crlf();
      put_crlf();
      send_frame();
      put_str("HTTP/1.1 2x0 OK");
      put_crlf();
      put_crlf();
      send_frame();
      put_str("HTTP/1.1");
      put_crlf();
      put_crlf();
      send_frame();
      wait_all_tags();
   endtask

   task automatic test_bad_first_lines();
      put_crlf();
      put_str("Host: a");
      put_crlf();
      put_crlf();
      send_frame();
      put_str("PUT / HTTP/1.1");
      put_crlf();
      put_crlf();
      send_frame();
      put_str("GE");
      put_crlf();
      put_crlf();
      send_frame();
      put_str("get / HTTP/1.1");
      put_crlf();
      put_crlf();
      send_frame();
      wait_all_tags();
   endtask

   task automatic test_line_breaks();
      // A CR that is not followed by LF comes out as content.
      put_str("GET /a");
      put_byte(CH_CR);
      put_str("b HTTP/1.1");
      put_crlf();
      put_str("Ke");
      put_byte(CH_CR);
      put_str(":va");
      put_byte(CH_CR);
      put_str("l");
      put_crlf();
      put_str("@AZ[`az{: @AZ[`az{");
      put_crlf();
      put_byte(8'hFF);
      put_byte(CH_COLON);
      put_byte(8'h00);
      put_byte(8'h80);
      put_crlf();
      put_crlf();
      send_frame();
      // Bytes after the empty line pass through, and CR is not held there.
      put_str("GET / HTTP/1.1");
      put_crlf();
      put_crlf();
      put_str("tail");
      put_byte(CH_CR);
      put_str("x");
      put_crlf();
      put_crlf();
      send_frame();
      put_str("GET / HTTP/1.1");
      put_crlf();
      put_str("A: b");
      put_crlf();
      send_frame();
      put_str("GET / HTTP/1.1");
      put_crlf();
      put_str("A: b");
      put_byte(CH_CR);
      put_str("x");
      send_frame();
      put_byte(8'h00);
      send_frame();
      put_byte(8'hFF);
      send_frame();
      wait_all_tags();
   endtask

   // A long run of random bytes after the header, sent at full rate.
   task automatic test_long_buffer();
      idle_on = 1'b0;
      put_str("GET / HTTP/1.1");
      put_crlf();
      put_crlf();
      repeat (LONG_FILL) put_byte(byte_type'($urandom_range(0, 255)));
      put_crlf();
      put_crlf();
      send_frame();
      put_str("GET / HTTP/1.1");
      put_crlf();
      put_crlf();
      send_frame();
      wait_all_tags();
      idle_on = 1'b1;
   endtask

   task automatic put_request(input string verb);
      int unsigned n;
      byte_type    c;
      put_str(verb);
      if ($urandom_range(0, 7) != 0) put_byte(CH_SPACE);
      n = $urandom_range(0, 10);
      repeat (n) begin
         c = byte_type'($urandom_range(33, 126));
         put_byte(c);
      end
      if ($urandom_range(0, 3) != 0) put_str(" HTTP/1.1");
   endtask

   task automatic build_random_frame();
      int unsigned shape;
      int unsigned n;
      int unsigned lines;
      byte_type    c;
      shape = $urandom_range(0, 99);
      if (shape < 8) begin
         n = $urandom_range(1, 24);
         repeat (n) put_byte(byte_type'($urandom_range(0, 255)));
      end else begin
         if (shape < 11) put_crlf();
         case ($urandom_range(0, 5)) inside
            0: put_request("GET");
            1: put_request("POST");
            2: put_request("HEAD");
            [3:4]: begin
               put_str("HTTP/1.");
               put_byte(byte_type'($urandom_range(CH_ZERO, CH_NINE)));
               if ($urandom_range(0, 7) != 0) put_byte(CH_SPACE);
               n = $urandom_range(0, 4);
               repeat (n) begin
                  if ($urandom_range(0, 9) != 0)
                     put_byte(byte_type'($urandom_range(CH_ZERO, CH_NINE)));
                  else put_byte(byte_type'($urandom_range(32, 126)));
               end
               if ($urandom_range(0, 1) != 0) put_str(" OK");
            end
            default: begin
               n = $urandom_range(1, 5);
               repeat (n) put_byte(byte_type'($urandom_range(33, 126)));
               put_str(" /x");
            end
         endcase
         put_crlf();
         lines = $urandom_range(0, 5);
         repeat (lines) begin
            n = $urandom_range(1, 10);
            repeat (n) begin
               c = byte_type'($urandom_range(32, 126));
               put_byte((c == CH_COLON) ? CH_SEMI : c);
            end
            if ($urandom_range(0, 6) != 0) begin
               put_byte(CH_COLON);
               n = $urandom_range(0, 14);
               repeat (n) begin
                  case ($urandom_range(0, 19))
                     0: put_byte(CH_CR);
                     1: put_byte(CH_SEMI);
                     default: put_byte(byte_type'($urandom_range(32, 126)));
                  endcase
               end
            end
            put_crlf();
         end
         if ($urandom_range(0, 9) != 0) put_crlf();
         if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) put_byte(byte_type'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) != 0) begin
               put_crlf();
               put_crlf();
            end
         end
         if ($urandom_range(0, 19) == 0)
            frame_q[$urandom_range(0, frame_q.size() - 1)] =
               byte_type'($urandom_range(0, 255));
         if ($urandom_range(0, 19) == 0 && frame_q.size() > 3)
            repeat ($urandom_range(1, 3)) void'(frame_q.pop_back());
      end
   endtask

   task automatic test_random_headers();
      int unsigned start_count;
      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         idle_on = ($urandom_range(0, 4) != 0);
         build_random_frame();
         send_frame();
         if ($urandom_range(0, 15) == 0) wait_all_tags();
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_request_lines();
      test_status_lines();
      test_bad_first_lines();
      test_line_breaks();
      test_long_buffer();
      test_random_headers();
      wait_all_tags();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/hhtok_pkg.sv
hdl/http_header_tokenizer.sv
sim/tb_top.sv
